FILE: src/emla_pkg.sv
// ----------------------------------------------------------------------------
// emla_pkg
// Shared types and codes for the extrema local mean and amplitude unit.
// ----------------------------------------------------------------------------
package emla_pkg;

	typedef logic [2:0] mul_sel_t;

	localparam mul_sel_t MUL_T2SQ = 3'd0;
	localparam mul_sel_t MUL_T1SQ = 3'd1;
	localparam mul_sel_t MUL_WA   = 3'd2;
	localparam mul_sel_t MUL_WC   = 3'd3;
	localparam mul_sel_t MUL_Y0   = 3'd4;
	localparam mul_sel_t MUL_Y2   = 3'd5;

	typedef struct packed {
		logic     store;
		logic     store_slot;
		logic     load;
		logic     setup;
		logic     div_step;
		logic     ratio;
		logic     lin_weights;
		logic     p2_cap;
		logic     p1_cap;
		logic     wa_cap;
		logic     wc_cap;
		mul_sel_t mul_sel;
		logic     acc_init;
		logic     acc_add;
		logic     out_load;
		logic     slide;
	} emla_cmd_t;

	typedef struct packed {
		logic den_zero;
	} emla_status_t;

endpackage

FILE: src/emla_ifs.sv
// ----------------------------------------------------------------------------
// emla channel interfaces
// Valid/ready channels for extrema going in and local mean results going out.
// ----------------------------------------------------------------------------
interface emla_in_if #(
	parameter int POS_BITS    = 16,
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic                          start_run;
	logic [POS_BITS-1:0]           extr_pos;
	logic signed [SAMPLE_BITS-1:0] extr_value;

	modport source (output valid, start_run, extr_pos, extr_value, input ready);
	modport sink (input valid, start_run, extr_pos, extr_value, output ready);
endinterface

interface emla_out_if #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
);
	localparam int OW = SAMPLE_BITS + FRAC_BITS + 1;

	logic                 valid;
	logic                 ready;
	logic signed [OW-1:0] local_mean;
	logic signed [OW-1:0] local_amplitude;
	logic                 bad_spacing;

	modport source (output valid, local_mean, local_amplitude, bad_spacing, input ready);
	modport sink (input valid, local_mean, local_amplitude, bad_spacing, output ready);
endinterface

FILE: src/emla_ctrl.sv
// ----------------------------------------------------------------------------
// emla_ctrl
// Sequencer: window fill tracking, divide count, multiply schedule, result beat.
// ----------------------------------------------------------------------------
module emla_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_start_run,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  emla_pkg::emla_status_t status,
	output emla_pkg::emla_cmd_t    cmd
);

	localparam int CW = $clog2(FRAC_BITS);
	localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS - 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SETUP = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_RATIO = 4'd3;
	localparam logic [3:0] ST_SQ2   = 4'd4;
	localparam logic [3:0] ST_SQ1   = 4'd5;
	localparam logic [3:0] ST_WA    = 4'd6;
	localparam logic [3:0] ST_WC    = 4'd7;
	localparam logic [3:0] ST_M0    = 4'd8;
	localparam logic [3:0] ST_M1    = 4'd9;
	localparam logic [3:0] ST_M2    = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	logic [3:0]    state_q;
	logic [3:0]    state_n;
	logic [1:0]    fill_q;
	logic [1:0]    eff_fill;
	logic [CW-1:0] cnt_q;
	logic          mode_q;
	logic          out_valid_q;
	logic          accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign eff_fill  = in_start_run ? 2'd0 : fill_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (eff_fill != 2'd2) begin
						cmd.store      = 1'b1;
						cmd.store_slot = eff_fill[0];
					end else begin
						cmd.load = 1'b1;
						state_n  = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				if (status.den_zero) begin
					state_n = ST_FIN;
				end else begin
					cmd.setup = 1'b1;
					state_n   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_n = ST_RATIO;
				end
			end
			ST_RATIO: begin
				cmd.ratio       = 1'b1;
				cmd.lin_weights = mode_q;
				state_n         = mode_q ? ST_M0 : ST_SQ2;
			end
			ST_SQ2: begin
				cmd.mul_sel = emla_pkg::MUL_T2SQ;
				state_n     = ST_SQ1;
			end
			ST_SQ1: begin
				cmd.p2_cap  = 1'b1;
				cmd.mul_sel = emla_pkg::MUL_T1SQ;
				state_n     = ST_WA;
			end
			ST_WA: begin
				cmd.p1_cap  = 1'b1;
				cmd.mul_sel = emla_pkg::MUL_WA;
				state_n     = ST_WC;
			end
			ST_WC: begin
				cmd.wa_cap  = 1'b1;
				cmd.mul_sel = emla_pkg::MUL_WC;
				state_n     = ST_M0;
			end
			ST_M0: begin
				cmd.wc_cap  = ~mode_q;
				cmd.mul_sel = emla_pkg::MUL_Y0;
				state_n     = ST_M1;
			end
			ST_M1: begin
				cmd.acc_init = 1'b1;
				cmd.mul_sel  = emla_pkg::MUL_Y2;
				state_n      = ST_M2;
			end
			ST_M2: begin
				cmd.acc_add = 1'b1;
				state_n     = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.slide    = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= 2'd0;
			cnt_q       <= '0;
			mode_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.store) begin
				fill_q <= eff_fill + 2'd1;
			end
			if (cmd.setup) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/emla_datapath.sv
// ----------------------------------------------------------------------------
// emla_datapath
// Extrema window, two serial ratio dividers, shared multiplier and accumulator.
// ----------------------------------------------------------------------------
module emla_datapath #(
	parameter int POS_BITS    = 16,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                   clk,
	input  emla_pkg::emla_cmd_t                    cmd,
	output emla_pkg::emla_status_t                 status,
	input  logic [POS_BITS-1:0]                    extr_pos,
	input  logic signed [SAMPLE_BITS-1:0]          extr_value,
	output logic signed [SAMPLE_BITS+FRAC_BITS:0]  local_mean,
	output logic signed [SAMPLE_BITS+FRAC_BITS:0]  local_amplitude,
	output logic                                   bad_spacing
);

	localparam int P  = POS_BITS;
	localparam int S  = SAMPLE_BITS;
	localparam int F  = FRAC_BITS;
	localparam int TW = F + 1;
	localparam int MA = F + 3;
	localparam int MB = (S > F + 2) ? S : F + 2;
	localparam int PW = MA + MB;
	localparam int AW = S + F + 4;
	localparam int OW = S + F + 1;

	localparam logic [TW-1:0]        T_ONE  = {1'b1, {F{1'b0}}};
	localparam logic signed [PW-1:0] HALF_P = PW'(1) << (F - 1);
	localparam logic signed [AW-1:0] ONE_A  = AW'(1);
	localparam logic signed [AW-1:0] HI_O   = AW'((AW'(1) << (OW - 1)) - AW'(1));
	localparam logic signed [AW-1:0] LO_O   = ~HI_O;

	logic [P-1:0]          win_pos_q [2];
	logic signed [S-1:0]   win_val_q [2];
	logic [P-1:0]          x2_q;
	logic signed [S-1:0]   y2_q;
	logic signed [P:0]     d1_q;
	logic signed [P:0]     d2_q;
	logic signed [P:0]     den_q;
	logic                  bad_q;
	logic [P-1:0]          den_abs_q;
	logic [P-1:0]          r1_q;
	logic [P-1:0]          r2_q;
	logic [F-1:0]          q1_q;
	logic [F-1:0]          q2_q;
	logic                  sat1_q;
	logic                  sat2_q;
	logic [TW-1:0]         t1_q;
	logic [TW-1:0]         t2_q;
	logic signed [MA-1:0]  p1_q;
	logic signed [MA-1:0]  p2_q;
	logic signed [MA-1:0]  wa_q;
	logic signed [MA-1:0]  wc_q;
	logic signed [PW-1:0]  prod_s1;
	logic signed [AW-1:0]  acc_q;
	logic signed [OW-1:0]  mean_q;
	logic signed [OW-1:0]  amp_q;
	logic                  bad_out_q;

	logic signed [P:0]     d1_n;
	logic signed [P:0]     d2_n;
	logic signed [P:0]     den_n;
	logic [P:0]            abs1_w;
	logic [P:0]            abs2_w;
	logic [P:0]            absd_w;
	logic                  pos1;
	logic                  pos2;
	logic                  sat1;
	logic                  sat2;
	logic [P:0]            r1x;
	logic [P:0]            r2x;
	logic [P:0]            r1d;
	logic [P:0]            r2d;
	logic                  ge1;
	logic                  ge2;
	logic [TW-1:0]         t1_n;
	logic [TW-1:0]         t2_n;
	logic signed [MA-1:0]  mul_a;
	logic signed [MB-1:0]  mul_b;
	logic signed [PW-1:0]  mul_p;
	logic signed [PW-1:0]  rnd_sum;
	logic signed [PW-1:0]  rnd_w;
	logic signed [MA-1:0]  rnd_m;
	logic signed [AW-1:0]  prod_a;
	logic signed [AW-1:0]  y1_t;
	logic signed [AW-1:0]  sm_w;
	logic signed [AW-1:0]  sa_w;
	logic signed [AW-1:0]  sm_h;
	logic signed [AW-1:0]  sa_h;
	logic signed [AW-1:0]  sm_c;
	logic signed [AW-1:0]  sa_c;

	assign status.den_zero = bad_q;

	// window differences
	assign d1_n  = $signed({1'b0, win_pos_q[1]}) - $signed({1'b0, win_pos_q[0]});
	assign d2_n  = $signed({1'b0, extr_pos}) - $signed({1'b0, win_pos_q[1]});
	assign den_n = $signed({1'b0, extr_pos}) - $signed({1'b0, win_pos_q[0]});

	// ratio setup
	assign abs1_w = d1_q[P] ? -d1_q : d1_q;
	assign abs2_w = d2_q[P] ? -d2_q : d2_q;
	assign absd_w = den_q[P] ? -den_q : den_q;
	assign pos1   = (d1_q != '0) && (d1_q[P] == den_q[P]);
	assign pos2   = (d2_q != '0) && (d2_q[P] == den_q[P]);
	assign sat1   = pos1 && (abs1_w[P-1:0] >= absd_w[P-1:0]);
	assign sat2   = pos2 && (abs2_w[P-1:0] >= absd_w[P-1:0]);

	// restoring divide step
	assign r1x = {r1_q, 1'b0};
	assign r2x = {r2_q, 1'b0};
	assign ge1 = r1x >= {1'b0, den_abs_q};
	assign ge2 = r2x >= {1'b0, den_abs_q};
	assign r1d = ge1 ? (r1x - {1'b0, den_abs_q}) : r1x;
	assign r2d = ge2 ? (r2x - {1'b0, den_abs_q}) : r2x;

	assign t1_n = sat1_q ? T_ONE : {1'b0, q1_q};
	assign t2_n = sat2_q ? T_ONE : {1'b0, q2_q};

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			emla_pkg::MUL_T2SQ: begin
				mul_a = MA'($signed({1'b0, t2_q}));
				mul_b = MB'($signed({1'b0, t2_q}));
			end
			emla_pkg::MUL_T1SQ: begin
				mul_a = MA'($signed({1'b0, t1_q}));
				mul_b = MB'($signed({1'b0, t1_q}));
			end
			emla_pkg::MUL_WA: begin
				mul_a = MA'({t1_q, 1'b0}) + MA'(T_ONE);
				mul_b = MB'(p2_q);
			end
			emla_pkg::MUL_WC: begin
				mul_a = MA'(T_ONE) - MA'({t2_q, 1'b0});
				mul_b = MB'(p1_q);
			end
			emla_pkg::MUL_Y0: begin
				mul_a = wa_q;
				mul_b = MB'(win_val_q[0]);
			end
			emla_pkg::MUL_Y2: begin
				mul_a = wc_q;
				mul_b = MB'(y2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign rnd_sum = prod_s1 + HALF_P;
	assign rnd_w   = rnd_sum >>> F;
	assign rnd_m   = rnd_w[MA-1:0];
	assign prod_a  = AW'(prod_s1);

	// final round and saturate
	assign y1_t = AW'(win_val_q[1]) <<< F;
	assign sm_w = acc_q + y1_t + ONE_A;
	assign sa_w = acc_q - y1_t + ONE_A;
	assign sm_h = sm_w >>> 1;
	assign sa_h = sa_w >>> 1;
	assign sm_c = (sm_h > HI_O) ? HI_O : ((sm_h < LO_O) ? LO_O : sm_h);
	assign sa_c = (sa_h > HI_O) ? HI_O : ((sa_h < LO_O) ? LO_O : sa_h);

	always_ff @(posedge clk) begin
		prod_s1 <= mul_p;
		if (cmd.store) begin
			win_pos_q[cmd.store_slot] <= extr_pos;
			win_val_q[cmd.store_slot] <= extr_value;
		end
		if (cmd.slide) begin
			win_pos_q[0] <= win_pos_q[1];
			win_val_q[0] <= win_val_q[1];
			win_pos_q[1] <= x2_q;
			win_val_q[1] <= y2_q;
		end
		if (cmd.load) begin
			x2_q  <= extr_pos;
			y2_q  <= extr_value;
			d1_q  <= d1_n;
			d2_q  <= d2_n;
			den_q <= den_n;
			bad_q <= (den_n == '0);
		end
		if (cmd.setup) begin
			den_abs_q <= absd_w[P-1:0];
			r1_q      <= (pos1 && !sat1) ? abs1_w[P-1:0] : '0;
			r2_q      <= (pos2 && !sat2) ? abs2_w[P-1:0] : '0;
			sat1_q    <= sat1;
			sat2_q    <= sat2;
		end
		if (cmd.div_step) begin
			r1_q <= r1d[P-1:0];
			r2_q <= r2d[P-1:0];
			q1_q <= {q1_q[F-2:0], ge1};
			q2_q <= {q2_q[F-2:0], ge2};
		end
		if (cmd.ratio) begin
			t1_q <= t1_n;
			t2_q <= t2_n;
			if (cmd.lin_weights) begin
				wa_q <= MA'(t2_n);
				wc_q <= MA'(t1_n);
			end
		end
		if (cmd.p2_cap) begin
			p2_q <= rnd_m;
		end
		if (cmd.p1_cap) begin
			p1_q <= rnd_m;
		end
		if (cmd.wa_cap) begin
			wa_q <= rnd_m;
		end
		if (cmd.wc_cap) begin
			wc_q <= rnd_m;
		end
		if (cmd.acc_init) begin
			acc_q <= prod_a;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_a;
		end
		if (cmd.out_load) begin
			mean_q    <= bad_q ? '0 : sm_c[OW-1:0];
			amp_q     <= bad_q ? '0 : sa_c[OW-1:0];
			bad_out_q <= bad_q;
		end
	end

	assign local_mean      = mean_q;
	assign local_amplitude = amp_q;
	assign bad_spacing     = bad_out_q;

endmodule

FILE: src/extrema_local_mean_amplitude_unit.sv
// ----------------------------------------------------------------------------
// extrema_local_mean_amplitude_unit
// Three-extremum window giving local mean and amplitude at the middle extremum.
//
//   channel    | dir | payload                                      | handshake
//   extr_ch    | in  | start_run, extr_pos, extr_value              | valid/ready
//   result_ch  | out | local_mean, local_amplitude, bad_spacing     | valid/ready
//   cfg        | in  | cfg_wdata (weight_mode)                      | cfg_we
//
// an extremum that only fills the window is stored on acceptance and the unit stays ready
// a full window runs the bit-serial ratio dividers and then the single shared multiplier,
// with the squaring and weight steps added in cubic mode only
// equal outer positions go straight from setup to the result beat
// a pending result beat stalls only the final step; no extremum is taken meanwhile
// reset empties the window and selects linear weights
// ----------------------------------------------------------------------------
module extrema_local_mean_amplitude_unit #(
	parameter int POS_BITS    = 16,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	emla_in_if.sink    extr_ch,
	emla_out_if.source result_ch,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	emla_pkg::emla_cmd_t    cmd;
	emla_pkg::emla_status_t status;

	emla_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (extr_ch.valid),
		.in_start_run(extr_ch.start_run),
		.in_ready    (extr_ch.ready),
		.out_valid   (result_ch.valid),
		.out_ready   (result_ch.ready),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.status      (status),
		.cmd         (cmd)
	);

	emla_datapath #(
		.POS_BITS   (POS_BITS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.status         (status),
		.extr_pos       (extr_ch.extr_pos),
		.extr_value     (extr_ch.extr_value),
		.local_mean     (result_ch.local_mean),
		.local_amplitude(result_ch.local_amplitude),
		.bad_spacing    (result_ch.bad_spacing)
	);

endmodule
